[sv/smv_pkg.sv]
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types, register indexes and constants of the sphere mesh generator.
// ----------------------------------------------------------------------------
`default_nettype none
package smv_pkg;

  localparam int TRIG_FRAC_BITS_DEF  = 16;
  localparam int COORD_FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd2;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [7:0]  SLICES_RST = 8'd10;
  localparam logic [7:0]  STACKS_RST = 8'd10;

  localparam logic [1:0] SEC_TOP    = 2'd0;
  localparam logic [1:0] SEC_SIDE   = 2'd1;
  localparam logic [1:0] SEC_BOTTOM = 2'd2;

  localparam int COORD_W = 17;
  localparam int IDX_W   = 9;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] radius;
    logic [7:0]  slices;
    logic [7:0]  stacks;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] slice;
    logic [IDX_W-1:0] ring;
    logic             tri_end;
    logic             mesh_end;
  } vertex_t;

endpackage
`default_nettype wire

[sv/smv_in_if.sv]
// ----------------------------------------------------------------------------
// smv_in_if
// Input tick channel: valid, ready and the restart flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface smv_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface
`default_nettype wire

[sv/smv_out_if.sv]
// ----------------------------------------------------------------------------
// smv_out_if
// Vertex result channel: valid, ready, coordinates and end flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface smv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [smv_pkg::COORD_W-1:0] x_coord;
  logic signed [smv_pkg::COORD_W-1:0] y_coord;
  logic signed [smv_pkg::COORD_W-1:0] z_coord;
  logic                               triangle_end;
  logic                               mesh_end;
  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  output triangle_end, output mesh_end, input ready);
  modport sink (input valid, input x_coord, input y_coord, input z_coord,
                input triangle_end, input mesh_end, output ready);
endinterface
`default_nettype wire

[sv/smv_cfg_if.sv]
// ----------------------------------------------------------------------------
// smv_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
`default_nettype none
interface smv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [smv_pkg::CFG_IDX_W-1:0]     index;
  logic [smv_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/smv_front.sv]
// ----------------------------------------------------------------------------
// smv_front
// Vertex sequencer: walks caps and side quads, emits slice/ring per tick.
// ----------------------------------------------------------------------------
`default_nettype none
module smv_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire smv_pkg::cfg_t   cfg,
  smv_in_if.sink               vin,
  output smv_pkg::vertex_t     push_data,
  output logic                 push_valid,
  input  wire logic            push_ready
);

  logic [1:0] section, section_next;
  logic [7:0] slice_index, slice_index_next;
  logic [7:0] ring_index, ring_index_next;
  logic [2:0] corner_index, corner_index_next;

  logic [1:0] sec;
  logic [7:0] ci, cj;
  logic [2:0] ck;
  logic [8:0] n9, m9, i0, i1, j0, j1;
  logic       fire;

  assign fire       = vin.valid && push_ready;
  assign vin.ready  = push_ready;
  assign push_valid = vin.valid;

  always_comb begin
    if (vin.restart) begin
      sec = smv_pkg::SEC_TOP;
      ci  = 8'd0;
      cj  = 8'd1;
      ck  = 3'd0;
    end else begin
      sec = section;
      ci  = slice_index;
      cj  = ring_index;
      ck  = corner_index;
    end
    n9 = (cfg.slices == 8'd0) ? 9'd1 : {1'b0, cfg.slices};
    m9 = {1'b0, cfg.stacks};
    i0 = {1'b0, ci};
    i1 = i0 + 9'd1;
    j0 = {1'b0, cj};
    j1 = j0 + 9'd1;

    section_next      = sec;
    slice_index_next  = ci;
    ring_index_next   = cj;
    corner_index_next = ck + 3'd1;
    push_data.slice   = i0;
    push_data.ring    = j0;
    push_data.tri_end = 1'b0;
    push_data.mesh_end = 1'b0;

    case (sec)
      smv_pkg::SEC_TOP: begin
        push_data.slice = (ck >= 3'd2) ? i1 : i0;
        push_data.ring  = (ck == 3'd0) ? 9'd0 : 9'd1;
        if (ck >= 3'd2) begin
          push_data.tri_end = 1'b1;
          corner_index_next = 3'd0;
          if (i1 >= n9) begin
            slice_index_next = 8'd0;
            ring_index_next  = 8'd1;
            section_next     = (m9 == 9'd0) ? smv_pkg::SEC_BOTTOM : smv_pkg::SEC_SIDE;
          end else begin
            slice_index_next = i1[7:0];
          end
        end
      end
      smv_pkg::SEC_SIDE: begin
        case (ck)
          3'd0: begin push_data.slice = i0; push_data.ring = j0; end
          3'd1: begin push_data.slice = i0; push_data.ring = j1; end
          3'd2: begin push_data.slice = i1; push_data.ring = j0; end
          3'd3: begin push_data.slice = i1; push_data.ring = j0; end
          3'd4: begin push_data.slice = i0; push_data.ring = j1; end
          default: begin push_data.slice = i1; push_data.ring = j1; end
        endcase
        if (ck == 3'd2) push_data.tri_end = 1'b1;
        if (ck >= 3'd5) begin
          push_data.tri_end = 1'b1;
          corner_index_next = 3'd0;
          if (j1 > m9) begin
            ring_index_next = 8'd1;
            if (i1 >= n9) begin
              slice_index_next = 8'd0;
              section_next     = smv_pkg::SEC_BOTTOM;
            end else begin
              slice_index_next = i1[7:0];
            end
          end else begin
            ring_index_next = j1[7:0];
          end
        end
      end
      default: begin
        push_data.slice = (ck >= 3'd2) ? i1 : i0;
        push_data.ring  = (ck == 3'd0) ? (m9 + 9'd2) : (m9 + 9'd1);
        if (ck >= 3'd2) begin
          push_data.tri_end = 1'b1;
          if (i1 >= n9) begin
            push_data.mesh_end = 1'b1;
            section_next      = smv_pkg::SEC_TOP;
            slice_index_next  = 8'd0;
            ring_index_next   = 8'd1;
            corner_index_next = 3'd0;
          end else begin
            slice_index_next  = i1[7:0];
            corner_index_next = 3'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section      <= smv_pkg::SEC_TOP;
      slice_index  <= 8'd0;
      ring_index   <= 8'd1;
      corner_index <= 3'd0;
    end else if (fire) begin
      section      <= section_next;
      slice_index  <= slice_index_next;
      ring_index   <= ring_index_next;
      corner_index <= corner_index_next;
    end
  end

endmodule
`default_nettype wire

[sv/smv_queue.sv]
// ----------------------------------------------------------------------------
// smv_queue
// Short FIFO of vertex indexes between sequencer and arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none
module smv_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire smv_pkg::vertex_t  push_data,
  input  wire logic              push_valid,
  output logic                   push_ready,
  output smv_pkg::vertex_t       pop_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready
);

  localparam int DEPTH = smv_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  smv_pkg::vertex_t entry [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

[sv/smv_back.sv]
// ----------------------------------------------------------------------------
// smv_back
// Vertex arithmetic: angle division, series sine/cosine, scaling, rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module smv_back #(
  parameter int TRIG_FRAC_BITS  = smv_pkg::TRIG_FRAC_BITS_DEF,
  parameter int COORD_FRAC_BITS = smv_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire smv_pkg::cfg_t     cfg,
  input  wire smv_pkg::vertex_t  pop_data,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  smv_out_if.source              vout
);

  localparam int T   = TRIG_FRAC_BITS;
  localparam int TMW = T + 1;
  localparam int MA  = (17 + T > 32) ? 17 + T : 32;
  localparam int PW  = MA + 32;
  localparam int DW  = 42;
  localparam int SH1 = 8 + T - COORD_FRAC_BITS;
  localparam int SH2 = 8 + 2 * T - COORD_FRAC_BITS;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] TRIG_HALF = 31'(1) << (29 - T);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DIV  = 5'd1;
  localparam logic [4:0] ST_TX   = 5'd2;
  localparam logic [4:0] ST_TX2  = 5'd3;
  localparam logic [4:0] ST_TSET = 5'd4;
  localparam logic [4:0] ST_HP   = 5'd5;
  localparam logic [4:0] ST_HQ   = 5'd6;
  localparam logic [4:0] ST_HC   = 5'd7;
  localparam logic [4:0] ST_PS   = 5'd8;
  localparam logic [4:0] ST_PSS  = 5'd9;
  localparam logic [4:0] ST_TFIN = 5'd10;
  localparam logic [4:0] ST_C1   = 5'd11;
  localparam logic [4:0] ST_C2   = 5'd12;
  localparam logic [4:0] ST_C3   = 5'd13;
  localparam logic [4:0] ST_C4   = 5'd14;
  localparam logic [4:0] ST_C5   = 5'd15;
  localparam logic [4:0] ST_C6   = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  logic [4:0] state;

  logic [DW-1:0] dva, dvp;
  logic [9:0]    rema, remp;
  logic [31:0]   qa, qp;
  logic [5:0]    cnt;
  logic          tri_end, mesh_end;

  logic          pass, cosph;
  logic [2:0]    term;
  logic [29:0]   x, x2;
  logic [30:0]   t, v, ps;
  logic [TMW-1:0] sa_mag, ca_mag, sp_mag, cp_mag;
  logic          sa_neg, ca_neg, sp_neg, cp_neg;
  logic [PW-1:0] prod, xraw, yraw, zraw;

  logic [MA-1:0] mul_a;
  logic [31:0]   mul_b;

  logic [31:0]   phase;
  logic [2:0]    oct;
  logic [29:0]   ang;
  logic [7:0]    kval;
  logic [31:0]   recip;
  logic [29:0]   q0;
  logic [33:0]   rres;
  logic [30:0]   qc;
  logic [9:0]    ta, tp, n10, d10;
  logic [30:0]   pcv, spv, cpv, spr, cpr;
  logic [TMW-1:0] sr, cr;
  logic          sneg, cneg;
  logic [8:0]    nsl, dst;

  assign nsl = (cfg.slices == 8'd0) ? 9'd1 : {1'b0, cfg.slices};
  assign dst = {1'b0, cfg.stacks} + 9'd2;
  assign n10 = {1'b0, nsl};
  assign d10 = {1'b0, dst};
  assign ta  = {rema[8:0], dva[DW-1]};
  assign tp  = {remp[8:0], dvp[DW-1]};

  assign phase = pass ? qp : qa;
  assign oct   = phase[31:29];
  assign ang   = oct[0] ? (30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};

  always_comb begin
    case ({cosph, term})
      4'b0000: begin kval = 8'd110; recip = 32'd39045157;   end
      4'b0001: begin kval = 8'd72;  recip = 32'd59652323;   end
      4'b0010: begin kval = 8'd42;  recip = 32'd102261126;  end
      4'b0011: begin kval = 8'd20;  recip = 32'd214748364;  end
      4'b0100: begin kval = 8'd6;   recip = 32'd715827882;  end
      4'b1000: begin kval = 8'd132; recip = 32'd32537631;   end
      4'b1001: begin kval = 8'd90;  recip = 32'd47721858;   end
      4'b1010: begin kval = 8'd56;  recip = 32'd76695844;   end
      4'b1011: begin kval = 8'd30;  recip = 32'd143165576;  end
      4'b1100: begin kval = 8'd12;  recip = 32'd357913941;  end
      default: begin kval = 8'd2;   recip = 32'd2147483648; end
    endcase
  end

  assign q0   = prod[61:32];
  assign rres = {3'b0, v} - ({4'b0, q0} * {26'b0, kval});
  assign qc   = {1'b0, q0} + ((rres >= {26'b0, kval}) ? 31'd1 : 31'd0);

  assign pcv = t;
  assign spv = oct[0] ? pcv : ps;
  assign cpv = oct[0] ? ps : pcv;
  assign spr = (spv + TRIG_HALF) >> (30 - T);
  assign cpr = (cpv + TRIG_HALF) >> (30 - T);

  always_comb begin
    case (oct[2:1])
      2'd0:    begin sr = spr[TMW-1:0]; sneg = 1'b0; cr = cpr[TMW-1:0]; cneg = 1'b0; end
      2'd1:    begin sr = cpr[TMW-1:0]; sneg = 1'b0; cr = spr[TMW-1:0]; cneg = 1'b1; end
      2'd2:    begin sr = spr[TMW-1:0]; sneg = 1'b1; cr = cpr[TMW-1:0]; cneg = 1'b1; end
      default: begin sr = cpr[TMW-1:0]; sneg = 1'b1; cr = spr[TMW-1:0]; cneg = 1'b0; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_TX:  begin mul_a = MA'(ang);          mul_b = 32'(PI4_Q30); end
      ST_TX2: begin mul_a = MA'(prod[58:29]);  mul_b = 32'(prod[58:29]); end
      ST_HP:  begin mul_a = MA'(x2);           mul_b = 32'(t); end
      ST_HQ:  begin mul_a = MA'(prod[60:30]);  mul_b = recip; end
      ST_PS:  begin mul_a = MA'(x);            mul_b = 32'(t); end
      ST_C1:  begin mul_a = MA'(cfg.radius);   mul_b = 32'(ca_mag); end
      ST_C2:  begin mul_a = prod[MA-1:0];      mul_b = 32'(sp_mag); end
      ST_C3:  begin mul_a = MA'(cfg.radius);   mul_b = 32'(sa_mag); end
      ST_C4:  begin mul_a = prod[MA-1:0];      mul_b = 32'(sp_mag); end
      ST_C5:  begin mul_a = MA'(cfg.radius);   mul_b = 32'(cp_mag); end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  function automatic logic [smv_pkg::COORD_W-1:0] rnd_coord(
    input logic [PW-1:0] raw, input int sh, input logic neg);
    logic [PW-1:0] r;
    logic [smv_pkg::COORD_W-1:0] m;
    r = (raw >> sh) + PW'(raw[sh-1]);
    if (r > PW'(65535)) r = PW'(65535);
    m = r[smv_pkg::COORD_W-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dva      <= {1'b0, pop_data.slice, 32'b0} + DW'(nsl >> 1);
        dvp      <= {2'b0, pop_data.ring, 31'b0} + DW'(dst >> 1);
        rema     <= '0;
        remp     <= '0;
        tri_end  <= pop_data.tri_end;
        mesh_end <= pop_data.mesh_end;
        cnt      <= 6'(DW - 1);
        pass     <= 1'b0;
      end
      ST_DIV: begin
        dva <= {dva[DW-2:0], 1'b0};
        dvp <= {dvp[DW-2:0], 1'b0};
        if (ta >= n10) begin
          rema <= ta - n10;
          qa   <= {qa[30:0], 1'b1};
        end else begin
          rema <= ta;
          qa   <= {qa[30:0], 1'b0};
        end
        if (tp >= d10) begin
          remp <= tp - d10;
          qp   <= {qp[30:0], 1'b1};
        end else begin
          remp <= tp;
          qp   <= {qp[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      ST_TX2: x <= prod[58:29];
      ST_TSET: begin
        x2    <= prod[59:30];
        t     <= ONE_Q30;
        term  <= 3'd0;
        cosph <= 1'b0;
      end
      ST_HQ: v <= prod[60:30];
      ST_HC: begin
        t    <= ONE_Q30 - qc;
        term <= term + 3'd1;
      end
      ST_PSS: begin
        ps    <= prod[60:30];
        t     <= ONE_Q30;
        term  <= 3'd0;
        cosph <= 1'b1;
      end
      ST_TFIN: begin
        if (!pass) begin
          sa_mag <= sr; sa_neg <= sneg && (sr != '0);
          ca_mag <= cr; ca_neg <= cneg && (cr != '0);
        end else begin
          sp_mag <= sr; sp_neg <= sneg && (sr != '0);
          cp_mag <= cr; cp_neg <= cneg && (cr != '0);
        end
        pass <= 1'b1;
      end
      ST_C3: xraw <= prod;
      ST_C5: zraw <= prod;
      ST_C6: yraw <= prod;
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!vout.valid || vout.ready)) begin
      vout.x_coord      <= rnd_coord(xraw, SH2, ca_neg ^ sp_neg);
      vout.z_coord      <= rnd_coord(zraw, SH2, sa_neg ^ sp_neg);
      vout.y_coord      <= rnd_coord(yraw, SH1, cp_neg);
      vout.triangle_end <= tri_end;
      vout.mesh_end     <= mesh_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vout.valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!vout.valid || vout.ready)) begin
        vout.valid <= 1'b1;
      end else if (vout.valid && vout.ready) begin
        vout.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (pop_valid) state <= ST_DIV;
        ST_DIV:  if (cnt == 6'd0) state <= ST_TX;
        ST_TX:   state <= ST_TX2;
        ST_TX2:  state <= ST_TSET;
        ST_TSET: state <= ST_HP;
        ST_HP:   state <= ST_HQ;
        ST_HQ:   state <= ST_HC;
        ST_HC: begin
          if (!cosph && term == 3'd4) state <= ST_PS;
          else if (cosph && term == 3'd5) state <= ST_TFIN;
          else state <= ST_HP;
        end
        ST_PS:   state <= ST_PSS;
        ST_PSS:  state <= ST_HP;
        ST_TFIN: state <= pass ? ST_C1 : ST_TX;
        ST_C1:   state <= ST_C2;
        ST_C2:   state <= ST_C3;
        ST_C3:   state <= ST_C4;
        ST_C4:   state <= ST_C5;
        ST_C5:   state <= ST_C6;
        ST_C6:   state <= ST_OUT;
        ST_OUT: begin
          if (!vout.valid || vout.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/sphere_mesh_vertex_generator.sv]
// ----------------------------------------------------------------------------
// sphere_mesh_vertex_generator
// UV sphere triangle-list generator, one vertex per input transaction.
// ----------------------------------------------------------------------------
// Channels: vin takes one tick per transaction (restart = 1 starts over at the
// first vertex of the mesh); vout delivers one vertex per tick with its
// coordinates in Q.COORD_FRAC_BITS and the triangle and mesh end flags; cfg
// writes radius, slices and stacks by index; the user must write them only
// while the block is idle, as the block itself does not enforce it.
// A sequencer takes ticks into a two-entry queue; the arithmetic back end
// takes one entry at a time: it takes the entry, runs the two bit-serial
// angle dividers side by side, evaluates the Horner sine/cosine for each
// angle on the single shared multiplier, forms the coordinate products and
// loads the output register, and only then takes the next entry.
// A stalled receiver holds the vertex in the output register; the back end
// waits and the queue absorbs up to two further ticks before vin deasserts
// ready. Reset (rst, synchronous) restores radius 1.0, ten slices, ten
// stacks, empties the queue and returns the sequence to the top cap.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_mesh_vertex_generator #(
  parameter int TRIG_FRAC_BITS  = smv_pkg::TRIG_FRAC_BITS_DEF,
  parameter int COORD_FRAC_BITS = smv_pkg::COORD_FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  smv_in_if.sink    vin,
  smv_out_if.source vout,
  smv_cfg_if.sink   cfg
);

  smv_pkg::cfg_t    cfg_reg;
  smv_pkg::vertex_t push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.radius <= smv_pkg::RADIUS_RST;
      cfg_reg.slices <= smv_pkg::SLICES_RST;
      cfg_reg.stacks <= smv_pkg::STACKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        smv_pkg::REG_RADIUS: cfg_reg.radius <= cfg.data;
        smv_pkg::REG_SLICES: cfg_reg.slices <= cfg.data[7:0];
        smv_pkg::REG_STACKS: cfg_reg.stacks <= cfg.data[7:0];
        default: begin end
      endcase
    end
  end

  smv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_reg),
    .vin        (vin),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  smv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  smv_back #(
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_reg),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .vout      (vout)
  );

endmodule
`default_nettype wire

[verif/sphere_mesh_vertex_generator_tb.sv]
// ----------------------------------------------------------------------------
// sphere_mesh_vertex_generator_tb
// Drives restart ticks and register writes into the sphere mesh generator and
// compares every vertex against a fixed-point UV sphere predictor held here:
// reset defaults, register corner values, random small meshes with random
// restarts, large shapes, and a final run with no idling on either side.
// ----------------------------------------------------------------------------
module sphere_mesh_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_Q30  = 64'd1 << 30;
  localparam longint unsigned PI4_Q30  = 64'd843314857;
  localparam longint unsigned COORD_MAX = 64'd65535;
  localparam int TFB = smv_pkg::TRIG_FRAC_BITS_DEF;
  localparam int SHIFT_XZ = 8 + 2 * TFB - smv_pkg::COORD_FRAC_BITS_DEF;
  localparam int SHIFT_Y  = 8 + TFB - smv_pkg::COORD_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic signed [smv_pkg::COORD_W-1:0] x;
    logic signed [smv_pkg::COORD_W-1:0] y;
    logic signed [smv_pkg::COORD_W-1:0] z;
    logic                               tri_end;
    logic                               mesh_end;
  } vertex_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smv_in_if  vin();
  smv_out_if vout();
  smv_cfg_if cfg();

  sphere_mesh_vertex_generator dut (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin),
    .vout (vout),
    .cfg  (cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vertex_exp_t vertex_q[$];
  logic [15:0] mdl_radius;
  logic [7:0]  mdl_slices;
  logic [7:0]  mdl_stacks;
  logic [1:0]  mdl_sec;
  int unsigned mdl_slice;
  int unsigned mdl_ring;
  int unsigned mdl_corner;
  int errors = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  bit ready_run = 1'b0;

  function automatic void sincos(input logic [31:0] ph, output longint s,
                                 output longint c);
    logic [2:0] oct;
    longint unsigned r, a, x, x2, t, ps, pc, sp, cp;
    longint unsigned ks[5] = '{110, 72, 42, 20, 6};
    longint unsigned kc[6] = '{132, 90, 56, 30, 12, 2};
    oct = ph[31:29];
    r = ph[28:0];
    a = oct[0] ? ((64'd1 << 29) - r) : r;
    x = (a * PI4_Q30) >> 29;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 5; k++) t = ONE_Q30 - ((x2 * t) >> 30) / ks[k];
    ps = (x * t) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 6; k++) t = ONE_Q30 - ((x2 * t) >> 30) / kc[k];
    pc = t;
    if (oct[0]) begin
      sp = pc; cp = ps;
    end else begin
      sp = ps; cp = pc;
    end
    sp = (sp + (64'd1 << (29 - TFB))) >> (30 - TFB);
    cp = (cp + (64'd1 << (29 - TFB))) >> (30 - TFB);
    case (oct[2:1])
      2'd0: begin s = sp;  c = cp;  end
      2'd1: begin s = cp;  c = -longint'(sp); end
      2'd2: begin s = -longint'(sp); c = -longint'(cp); end
      default: begin s = -longint'(cp); c = sp; end
    endcase
  endfunction

  function automatic logic [smv_pkg::COORD_W-1:0] round_coord(
    input longint unsigned mag, input bit neg, input int sh);
    longint unsigned v;
    v = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
    if (v > COORD_MAX) v = COORD_MAX;
    if (neg) v = -v;
    return v[smv_pkg::COORD_W-1:0];
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void vertex_at(input int unsigned i, input int unsigned j,
                                    inout vertex_exp_t v);
    longint unsigned n, d;
    logic [31:0] paz, ppol;
    longint sa, ca, sp, cp;
    n = (mdl_slices == 0) ? 1 : mdl_slices;
    d = mdl_stacks + 2;
    paz = ((longint'(i) << 32) + n / 2) / n;
    ppol = ((longint'(j) << 31) + d / 2) / d;
    sincos(paz, sa, ca);
    sincos(ppol, sp, cp);
    v.x = round_coord(mdl_radius * mag(ca) * mag(sp), (ca < 0) != (sp < 0), SHIFT_XZ);
    v.y = round_coord(mdl_radius * mag(cp), cp < 0, SHIFT_Y);
    v.z = round_coord(mdl_radius * mag(sa) * mag(sp), (sa < 0) != (sp < 0), SHIFT_XZ);
  endfunction

  function automatic void rewind_mesh();
    mdl_sec = smv_pkg::SEC_TOP;
    mdl_slice = 0;
    mdl_ring = 1;
    mdl_corner = 0;
  endfunction

  function automatic vertex_exp_t next_vertex(input bit restart);
    vertex_exp_t v;
    int unsigned n, m, i, j, k;
    v = '0;
    n = (mdl_slices == 0) ? 1 : mdl_slices;
    m = mdl_stacks;
    if (restart) rewind_mesh();
    i = mdl_slice; j = mdl_ring; k = mdl_corner;
    if (mdl_sec == smv_pkg::SEC_TOP) begin
      if (k == 0) vertex_at(i, 0, v);
      else if (k == 1) vertex_at(i, 1, v);
      else vertex_at(i + 1, 1, v);
      if (k >= 2) begin
        v.tri_end = 1'b1;
        mdl_corner = 0;
        if (i + 1 >= n) begin
          mdl_slice = 0;
          mdl_ring = 1;
          mdl_sec = (m == 0) ? smv_pkg::SEC_BOTTOM : smv_pkg::SEC_SIDE;
        end else begin
          mdl_slice = i + 1;
        end
      end else begin
        mdl_corner = k + 1;
      end
    end else if (mdl_sec == smv_pkg::SEC_SIDE) begin
      case (k)
        0: vertex_at(i, j, v);
        1: vertex_at(i, j + 1, v);
        2: vertex_at(i + 1, j, v);
        3: vertex_at(i + 1, j, v);
        4: vertex_at(i, j + 1, v);
        default: vertex_at(i + 1, j + 1, v);
      endcase
      if (k == 2) v.tri_end = 1'b1;
      if (k >= 5) begin
        v.tri_end = 1'b1;
        mdl_corner = 0;
        if (j + 1 > m) begin
          mdl_ring = 1;
          if (i + 1 >= n) begin
            mdl_slice = 0;
            mdl_sec = smv_pkg::SEC_BOTTOM;
          end else begin
            mdl_slice = i + 1;
          end
        end else begin
          mdl_ring = j + 1;
        end
      end else begin
        mdl_corner = k + 1;
      end
    end else begin
      if (k == 0) vertex_at(i, m + 2, v);
      else if (k == 1) vertex_at(i, m + 1, v);
      else vertex_at(i + 1, m + 1, v);
      if (k >= 2) begin
        v.tri_end = 1'b1;
        if (i + 1 >= n) begin
          v.mesh_end = 1'b1;
          rewind_mesh();
        end else begin
          mdl_slice = i + 1;
          mdl_corner = 0;
        end
      end else begin
        mdl_corner = k + 1;
      end
    end
    return v;
  endfunction

  task automatic send_tick(input bit restart);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      vin.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    vin.valid = 1'b1;
    vin.restart = restart;
    do @(posedge clk); while (!vin.ready);
    vertex_q = {vertex_q, next_vertex(restart)};
    @(negedge clk);
  endtask

  task automatic drain();
    vin.valid = 1'b0;
    wait (vertex_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [smv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    drain();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      smv_pkg::REG_RADIUS: mdl_radius = val;
      smv_pkg::REG_SLICES: mdl_slices = val[7:0];
      smv_pkg::REG_STACKS: mdl_stacks = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_shape(input logic [15:0] r, input logic [15:0] sl,
                           input logic [15:0] st);
    write_reg(smv_pkg::REG_RADIUS, r);
    write_reg(smv_pkg::REG_SLICES, sl);
    write_reg(smv_pkg::REG_STACKS, st);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_register_extremes();
    set_shape(16'hFFFF, 16'd1, 16'd0);
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    set_shape(16'h0000, 16'd0, 16'd255);
    repeat (4) send_tick(1'b0);
    set_shape(16'hA5C3, 16'd255, 16'd254);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_random_meshes();
    int unsigned rate;
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 3))
        0: write_reg(smv_pkg::REG_RADIUS, 16'hFFFF);
        1: write_reg(smv_pkg::REG_RADIUS, 16'($urandom_range(0, 255)));
        default: write_reg(smv_pkg::REG_RADIUS, 16'($urandom_range(0, 65535)));
      endcase
      write_reg(smv_pkg::REG_SLICES,
                16'($urandom_range(0, 4) | ($urandom_range(0, 255) << 8)));
      write_reg(smv_pkg::REG_STACKS,
                16'($urandom_range(0, 3) | ($urandom_range(0, 255) << 8)));
      rate = (ph == 4) ? 3 : 40;
      for (int n = 0; n < 80; n++) send_tick($urandom_range(1, rate) == 1);
      if (ph == 2) drain();
    end
  endtask

  task automatic test_large_shapes();
    set_shape(16'($urandom_range(0, 65535)), 16'd255, 16'd255);
    for (int n = 0; n < 30; n++) send_tick($urandom_range(0, 29) == 0);
    set_shape(16'($urandom_range(0, 65535)), 16'($urandom_range(5, 255)),
              16'($urandom_range(4, 254)));
    for (int n = 0; n < 20; n++) send_tick(1'b0);
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    set_shape(16'd300, 16'd3, 16'd1);
    for (int n = 0; n < 40; n++) send_tick(1'b0);
    drain();
  endtask

  always @(negedge clk) begin
    if (ready_run) begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        vout.ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        vout.ready = 1'b1;
      end
    end
  end

  function automatic void report(input string fld, input int exp_v, input int act_v);
    $display("%0t: %s mismatch expected %0d actual %0d", $time, fld, exp_v, act_v);
    errors++;
  endfunction

  always @(posedge clk) begin
    vertex_exp_t e;
    if (!rst && vout.valid && vout.ready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex actual x %0d y %0d z %0d", $time,
                 vout.x_coord, vout.y_coord, vout.z_coord);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (vout.x_coord !== e.x) report("x_coord", e.x, vout.x_coord);
        if (vout.y_coord !== e.y) report("y_coord", e.y, vout.y_coord);
        if (vout.z_coord !== e.z) report("z_coord", e.z, vout.z_coord);
        if (vout.triangle_end !== e.tri_end)
          report("triangle_end", e.tri_end, vout.triangle_end);
        if (vout.mesh_end !== e.mesh_end) report("mesh_end", e.mesh_end, vout.mesh_end);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (vout.valid && vout.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sphere_mesh_vertex_generator test failed");
        $finish;
      end
    end
  end

  initial begin
    vin.valid = 1'b0;
    vin.restart = 1'b0;
    vout.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = smv_pkg::REG_RADIUS;
    cfg.data = '0;
    mdl_radius = smv_pkg::RADIUS_RST;
    mdl_slices = smv_pkg::SLICES_RST;
    mdl_stacks = smv_pkg::STACKS_RST;
    rewind_mesh();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    ready_run = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_meshes();
    test_large_shapes();
    test_no_idling();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("sphere_mesh_vertex_generator test passed");
    end else begin
      $display("sphere_mesh_vertex_generator test failed");
    end
    $finish;
  end

endmodule
